// File: rtl/core/tak_pkg.sv
// package with widths, reset values and register codes of the temperature alarm core
`default_nettype none

package tak_pkg;

  localparam int unsigned KEY_COUNT        = 3;
  localparam int unsigned DEBOUNCE_SAMPLES = 2;
  localparam int unsigned CNT_W            = 2;

  localparam int unsigned STEP_W = 7;
  localparam int unsigned THR_W  = 12;
  localparam int unsigned CLR_W  = 13;
  localparam int unsigned TEMP_W = 17;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [CODE_W-1:0] CODE_NEG_BASE = CODE_W'(10000);

  localparam logic [STEP_W-1:0] STEP_RST     = STEP_W'(5);
  localparam logic [THR_W-1:0]  HI_MAX_RST   = THR_W'(600);
  localparam logic [THR_W-1:0]  HI_MIN_RST   = THR_W'(-200);
  localparam logic [STEP_W-1:0] HYST_RST     = STEP_W'(10);
  localparam logic [THR_W-1:0]  THR_RST      = THR_W'(350);
  localparam logic [CLR_W-1:0]  CLR_RST      = CLR_W'(340);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP    = 8'd0,
    REG_HI_MAX  = 8'd1,
    REG_HI_MIN  = 8'd2,
    REG_HYST    = 8'd3
  } cfg_reg_e;

  typedef enum logic {
    ACT_KEY_TICK = 1'b0,
    ACT_READING  = 1'b1
  } action_e;

endpackage

`default_nettype wire

// File: rtl/core/temp_alarm_key_threshold_core.sv
// temperature alarm core with debounced keys and adjustable hysteresis threshold
//
// s_axis carries one beat per event: tuser = action (0 key tick, 1 reading),
// tdata = key levels, vendor temperature code and sensor online flag.
// m_axis returns exactly one beat per accepted input beat with the alarm
// flag, setting mode, both thresholds, last decoded temperature and the
// key press events of that beat.
// cfg writes one of four registers (step, upper clamp, lower clamp,
// hysteresis) per beat; cfg_ready_o is always high.
// m_axis_tvalid is registered and set by the edge that accepts the beat. The whole
// update is one combinational pass from the state registers into the state
// and result registers, so a beat is taken every cycle while the result
// register is empty or being drained.
// When the receiver stalls, the result register holds and s_axis_tready
// drops until it is taken. Reset clears the keys to released, leaves normal
// mode, sets threshold 35.0 and clear level 34.0 and loads register defaults.
`default_nettype none

module temp_alarm_key_threshold_core
  import tak_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [2:0] key_levels, [18:3] temp_code, [19] sensor_online, [23:20] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  wire logic                   s_axis_tuser,

  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [0] alarm_on, [1] setting_mode, [13:2] threshold_high,
  // [26:14] threshold_clear, [43:27] temp_tenths, [46:44] key_fired, [47] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,

  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // configuration registers
  logic [STEP_W-1:0] step_q;
  logic [THR_W-1:0]  hi_max_q;
  logic [THR_W-1:0]  hi_min_q;
  logic [STEP_W-1:0] hyst_q;

  // block state
  logic [KEY_COUNT-1:0]            lvl_q, lvl_d;
  logic [KEY_COUNT-1:0][CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_COUNT-1:0]            lat_q, lat_d;
  logic                            mode_q, mode_d;
  logic signed [THR_W-1:0]         thr_q, thr_d;
  logic signed [CLR_W-1:0]         clr_q, clr_d;
  logic                            alarm_q, alarm_d;
  logic signed [TEMP_W-1:0]        temp_q, temp_d;
  logic [KEY_COUNT-1:0]            fired_d, fired_q;

  logic out_valid_q;
  logic in_acc;

  logic [KEY_COUNT-1:0] in_keys;
  logic [CODE_W-1:0]    in_code;
  logic                 in_online;
  action_e              in_act;

  assign in_keys   = s_axis_tdata[KEY_COUNT-1:0];
  assign in_code   = s_axis_tdata[KEY_COUNT +: CODE_W];
  assign in_online = s_axis_tdata[KEY_COUNT+CODE_W];
  assign in_act    = action_e'(s_axis_tuser);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  function automatic logic signed [THR_W-1:0] adjust(
    input logic signed [THR_W-1:0] thr,
    input logic                    up,
    input logic [STEP_W-1:0]       step,
    input logic signed [THR_W-1:0] lim_max,
    input logic signed [THR_W-1:0] lim_min
  );
    logic signed [THR_W:0] t;
    logic signed [THR_W-1:0] res;
    if (up) begin
      t = $signed({thr[THR_W-1], thr}) + $signed({6'd0, step});
      if (t > $signed({lim_max[THR_W-1], lim_max})) res = lim_max;
      else res = t[THR_W-1:0];
    end else begin
      t = $signed({thr[THR_W-1], thr}) - $signed({6'd0, step});
      if (t < $signed({lim_min[THR_W-1], lim_min})) res = lim_min;
      else res = t[THR_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    logic [CNT_W-1:0]         cnt_nxt;
    logic [CODE_W-1:0]        code_off;
    logic signed [TEMP_W-1:0] temp_new;
    lvl_d    = lvl_q;
    cnt_d    = cnt_q;
    lat_d    = lat_q;
    mode_d   = mode_q;
    thr_d    = thr_q;
    clr_d    = clr_q;
    alarm_d  = alarm_q;
    temp_d   = temp_q;
    fired_d  = '0;
    cnt_nxt  = '0;
    code_off = in_code - CODE_NEG_BASE;
    temp_new = '0;
    if (in_act == ACT_KEY_TICK) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        cnt_nxt = cnt_d[i] + CNT_W'(1);
        if (in_keys[i] != lvl_d[i]) begin
          lvl_d[i] = in_keys[i];
          cnt_d[i] = '0;
        end else if (cnt_nxt < CNT_W'(DEBOUNCE_SAMPLES)) begin
          cnt_d[i] = cnt_nxt;
        end else begin
          cnt_d[i] = '0;
          if (in_keys[i]) begin
            lat_d[i] = 1'b0;
          end else if (!lat_d[i]) begin
            lat_d[i]   = 1'b1;
            fired_d[i] = 1'b1;
            if (i == 0) begin
              mode_d = !mode_d;
            end else if (mode_d) begin
              thr_d = adjust(thr_d, (i == 1), step_q, hi_max_q, hi_min_q);
              clr_d = $signed({thr_d[THR_W-1], thr_d}) - $signed({6'd0, hyst_q});
            end
          end
        end
      end
    end else begin
      if (!in_online) begin
        alarm_d = 1'b0;
      end else begin
        if (in_code < CODE_NEG_BASE) temp_new = $signed({1'b0, in_code});
        else temp_new = -$signed({1'b0, code_off});
        temp_d = temp_new;
        if (!alarm_q && temp_new > $signed({{(TEMP_W-THR_W){thr_q[THR_W-1]}}, thr_q}))
          alarm_d = 1'b1;
        else if (alarm_q &&
                 temp_new < $signed({{(TEMP_W-CLR_W){clr_q[CLR_W-1]}}, clr_q}))
          alarm_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_RST;
      hi_max_q <= HI_MAX_RST;
      hi_min_q <= HI_MIN_RST;
      hyst_q   <= HYST_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_STEP:   step_q   <= cfg_data_i[STEP_W-1:0];
        REG_HI_MAX: hi_max_q <= cfg_data_i[THR_W-1:0];
        REG_HI_MIN: hi_min_q <= cfg_data_i[THR_W-1:0];
        REG_HYST:   hyst_q   <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q       <= '1;
      cnt_q       <= '0;
      lat_q       <= '0;
      mode_q      <= 1'b0;
      thr_q       <= THR_RST;
      clr_q       <= CLR_RST;
      alarm_q     <= 1'b0;
      temp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        lvl_q   <= lvl_d;
        cnt_q   <= cnt_d;
        lat_q   <= lat_d;
        mode_q  <= mode_d;
        thr_q   <= thr_d;
        clr_q   <= clr_d;
        alarm_q <= alarm_d;
        temp_q  <= temp_d;
      end
      if (in_acc) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // result payload, shown together with the state it reflects
  always_ff @(posedge clk_i) begin
    if (in_acc) fired_q <= fired_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, fired_q, temp_q, clr_q, thr_q, mode_q, alarm_q};

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  a_reading_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser |=> m_axis_tdata[46:44] == 3'b000)
    else $error("key event reported on a reading");

  a_offline_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser && !s_axis_tdata[19] |=> !m_axis_tdata[0])
    else $error("offline reading left alarm set");

  a_tick_keeps_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tuser |=> alarm_q == $past(alarm_q))
    else $error("key tick changed alarm");
`endif

endmodule

`default_nettype wire

// File: tb/tb_temp_alarm_key_threshold_core.sv
// testbench for the temperature alarm core: debounced key ticks, readings and register writes
import tak_pkg::*;

localparam int unsigned KEY_LSB    = 0;
localparam int unsigned CODE_LSB   = KEY_LSB + KEY_COUNT;
localparam int unsigned ONLINE_BIT = CODE_LSB + CODE_W;
localparam int unsigned ALARM_BIT  = 0;
localparam int unsigned MODE_BIT   = 1;
localparam int unsigned THR_LSB    = 2;
localparam int unsigned CLR_LSB    = THR_LSB + THR_W;
localparam int unsigned TEMP_LSB   = CLR_LSB + CLR_W;
localparam int unsigned FIRED_LSB  = TEMP_LSB + TEMP_W;

typedef struct packed {
  logic                 alarm_on;
  logic                 setting_mode;
  logic [THR_W-1:0]     thr_high;
  logic [CLR_W-1:0]     thr_clear;
  logic [TEMP_W-1:0]    temp_tenths;
  logic [KEY_COUNT-1:0] key_fired;
} alarm_status_t;

class alarm_status_board;
  localparam int MODE_KEY  = 0;
  localparam int RAISE_KEY = 1;

  logic [STEP_W-1:0]    step;
  logic [THR_W-1:0]     hi_max;
  logic [THR_W-1:0]     hi_min;
  logic [STEP_W-1:0]    hyst;
  logic [KEY_COUNT-1:0] key_level;
  logic [KEY_COUNT-1:0] key_latched;
  logic [CNT_W-1:0]     key_agree [KEY_COUNT];
  logic                 mode;
  logic                 alarm;
  int                   thr;
  int                   clr;
  int                   temp;
  alarm_status_t        due_status [$];
  int                   errors;

  function new();
    step        = STEP_RST;
    hi_max      = HI_MAX_RST;
    hi_min      = HI_MIN_RST;
    hyst        = HYST_RST;
    key_level   = '1;
    key_latched = '0;
    foreach (key_agree[k]) key_agree[k] = '0;
    mode   = 1'b0;
    alarm  = 1'b0;
    thr    = int'($signed(THR_RST));
    clr    = int'($signed(CLR_RST));
    temp   = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_STEP:   step   = data[STEP_W-1:0];
      REG_HI_MAX: hi_max = data[THR_W-1:0];
      REG_HI_MIN: hi_min = data[THR_W-1:0];
      REG_HYST:   hyst   = data[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  function void nudge_threshold(bit up);
    int t;
    if (up) begin
      t = thr + int'(step);
      if (t > int'($signed(hi_max))) t = int'($signed(hi_max));
    end else begin
      t = thr - int'(step);
      if (t < int'($signed(hi_min))) t = int'($signed(hi_min));
    end
    thr = t;
    clr = t - int'(hyst);
  endfunction

  function logic [KEY_COUNT-1:0] scan_keys(logic [KEY_COUNT-1:0] levels);
    logic [KEY_COUNT-1:0] fired;
    fired = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (levels[k] != key_level[k]) begin
        key_level[k] = levels[k];
        key_agree[k] = '0;
      end else begin
        key_agree[k] = key_agree[k] + 1'b1;
        if (key_agree[k] >= DEBOUNCE_SAMPLES) begin
          key_agree[k] = '0;
          if (levels[k]) begin
            key_latched[k] = 1'b0;
          end else if (!key_latched[k]) begin
            key_latched[k] = 1'b1;
            fired[k]       = 1'b1;
            if (k == MODE_KEY) mode = ~mode;
            else if (mode) nudge_threshold(k == RAISE_KEY);
          end
        end
      end
    end
    return fired;
  endfunction

  function void take_reading(logic [CODE_W-1:0] code, logic online);
    if (!online) begin
      alarm = 1'b0;
    end else begin
      temp = (code < CODE_NEG_BASE) ? int'(code) : -int'(code - CODE_NEG_BASE);
      if (!alarm && temp > thr) alarm = 1'b1;
      else if (alarm && temp < clr) alarm = 1'b0;
    end
  endfunction

  function void accept_event(action_e act, logic [IN_TDATA_W-1:0] data);
    alarm_status_t s;
    s.key_fired = '0;
    if (act == ACT_KEY_TICK) s.key_fired = scan_keys(data[KEY_LSB +: KEY_COUNT]);
    else take_reading(data[CODE_LSB +: CODE_W], data[ONLINE_BIT]);
    s.alarm_on     = alarm;
    s.setting_mode = mode;
    s.thr_high     = THR_W'(thr);
    s.thr_clear    = CLR_W'(clr);
    s.temp_tenths  = TEMP_W'(temp);
    due_status.push_back(s);
  endfunction

  function void compare(realtime stamp, string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0.3f ns: %s expected 'h%0h actual 'h%0h", stamp, name, want, got);
      errors++;
    end
  endfunction

  function void check_status(logic [OUT_TDATA_W-1:0] data, realtime stamp);
    alarm_status_t want;
    if (due_status.size() == 0) begin
      $display("%0.3f ns: status beat with nothing due, actual 'h%0h", stamp, data);
      errors++;
      return;
    end
    want = due_status.pop_front();
    compare(stamp, "alarm_on", want.alarm_on, data[ALARM_BIT]);
    compare(stamp, "setting_mode", want.setting_mode, data[MODE_BIT]);
    compare(stamp, "threshold_high", want.thr_high, data[THR_LSB +: THR_W]);
    compare(stamp, "threshold_clear", want.thr_clear, data[CLR_LSB +: CLR_W]);
    compare(stamp, "temp_tenths", want.temp_tenths, data[TEMP_LSB +: TEMP_W]);
    compare(stamp, "key_fired", want.key_fired, data[FIRED_LSB +: KEY_COUNT]);
  endfunction
endclass

module tb_temp_alarm_key_threshold_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES       = 8;
  localparam int PHASE_EVENTS = 250;
  localparam int SETTLE       = 4;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  alarm_status_board    board = new();
  int                   src_idle_pct = 0;
  int                   sink_stall_pct = 0;
  int                   sink_hold_cycles = 0;
  logic [KEY_COUNT-1:0] held_keys = '1;

  temp_alarm_key_threshold_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stalls plus long hold-offs on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_status(m_axis_tdata, $realtime);
      if (s_axis_tvalid && s_axis_tready) board.accept_event(action_e'(s_axis_tuser), s_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  task automatic send_event(action_e act, logic [KEY_COUNT-1:0] keys, logic [CODE_W-1:0] code,
                            logic online);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[KEY_LSB +: KEY_COUNT] = keys;
    d[CODE_LSB +: CODE_W]   = code;
    d[ONLINE_BIT]           = online;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.due_status.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_phase(int p);
    case (p)
      1: begin
        program_reg(REG_STEP, 1);
        program_reg(REG_HI_MAX, 2000);
        program_reg(REG_HI_MIN, -2000);
        program_reg(REG_HYST, 0);
      end
      2: begin
        program_reg(REG_STEP, 100);
        program_reg(REG_HYST, 100);
      end
      3: begin
        // raw extremes of the register widths
        program_reg(REG_STEP, 127);
        program_reg(REG_HI_MAX, 2047);
        program_reg(REG_HI_MIN, -2048);
        program_reg(REG_HYST, 127);
      end
      4: begin
        // crossed clamps
        program_reg(REG_STEP, $urandom_range(1, 100));
        program_reg(REG_HI_MAX, -100);
        program_reg(REG_HI_MIN, 100);
      end
      5: begin
        program_reg(REG_STEP, $urandom_range(1, 100));
        program_reg(REG_HI_MAX, int'($urandom_range(0, 4000)) - 2000);
        program_reg(REG_HI_MIN, int'($urandom_range(0, 4000)) - 2000);
        program_reg(REG_HYST, $urandom_range(0, 100));
        program_reg(CFG_IDX_W'($urandom_range(int'(REG_HYST) + 1, 255)), $urandom);
      end
      6: begin
        program_reg(REG_STEP, 50);
        program_reg(REG_HI_MAX, 400);
        program_reg(REG_HI_MIN, 300);
        program_reg(REG_HYST, 5);
      end
      7: begin
        program_reg(REG_STEP, $urandom);
        program_reg(REG_HI_MAX, $urandom);
        program_reg(REG_HI_MIN, $urandom);
        program_reg(REG_HYST, $urandom);
      end
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    logic [KEY_COUNT-1:0] key_script [12];
    logic [CODE_W-1:0]    code_script [11];
    key_script  = '{3'b110, 3'b110, 3'b110, 3'b100, 3'b100, 3'b100,
                    3'b011, 3'b011, 3'b011, 3'b000, 3'b000, 3'b000};
    code_script = '{16'd0, 16'd9999, 16'd9999, 16'd10000, 16'hFFFF, 16'd351,
                    16'd340, 16'd339, 16'd350, 16'd9999, 16'd9999};
    foreach (key_script[n]) send_event(ACT_KEY_TICK, key_script[n], CODE_W'($urandom), n[0]);
    foreach (code_script[n])
      send_event(ACT_READING, KEY_COUNT'(n), code_script[n], n != $size(code_script) - 1);
  endtask

  task automatic random_event();
    logic [KEY_COUNT-1:0] keys;
    logic [CODE_W-1:0]    code;
    int                   target;
    int                   pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      for (int k = 0; k < KEY_COUNT; k++)
        if ($urandom_range(0, 99) < 30) held_keys[k] = ~held_keys[k];
      keys = ($urandom_range(0, 9) == 0) ? KEY_COUNT'($urandom) : held_keys;
      send_event(ACT_KEY_TICK, keys, CODE_W'($urandom), 1'($urandom));
    end else begin
      if (pick < 85) begin
        // aim around the clear and trigger levels
        target = board.clr - 15 + int'($urandom_range(0, board.thr - board.clr + 30));
        code = (target < 0) ? CODE_W'(int'(CODE_NEG_BASE) - target) : CODE_W'(target);
      end else if (pick < 90) begin
        code = CODE_NEG_BASE - CODE_W'(5) + CODE_W'($urandom_range(0, 10));
      end else begin
        code = CODE_W'($urandom);
      end
      send_event(ACT_READING, KEY_COUNT'($urandom), code, $urandom_range(0, 99) >= 8);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_KEY_TICK;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_STEP;
    cfg_data_i    = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      program_phase(p);
      src_idle_pct   = (p % 4 == 1) ? 56 : (p % 4 == 3) ? 38 : 0;
      sink_stall_pct = (p % 4 == 2) ? 56 : (p % 4 == 3) ? 38 : 0;
      for (int i = 0; i < PHASE_EVENTS; i++) begin
        if (p == 4 && i == 60) sink_hold_cycles = 300;
        if (p == 5 && i == 125) wait_drained();
        random_event();
      end
    end
    wait_drained();
    if (board.errors == 0 && board.due_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/tak_pkg.sv
rtl/core/temp_alarm_key_threshold_core.sv
tb/tb_temp_alarm_key_threshold_core.sv
